FILE: design/tpg_pkg.sv
// Shared types, constants and the tangent threshold table of the tunnel pixel generator.
package tpg_pkg;

   localparam int DefScreenWidth  = 320;
   localparam int DefScreenHeight = 200;

   localparam int TanFrac     = 48;
   localparam int SectorBits  = 5;
   localparam int RootBits    = 12;
   localparam int SqBits      = 23;
   localparam int R2Bits      = 22;
   localparam int MagBits     = 11;
   localparam int CoordBits   = 12;
   localparam int DepthSteps  = RootBits;
   localparam logic [SqBits-1:0] DepthScale = SqBits'(4194304);
   localparam real Pi = 3.14159265358979323846;

   typedef logic [TanFrac-1:0] tan_arr_type [2**SectorBits];

   // Fixed-point tan(s*pi/128) for the sector boundaries of one octant.
   function automatic tan_arr_type build_tan();
      tan_arr_type tab;
      real         t;
      for (int s = 0; s < 2**SectorBits; s++) begin
         t = $tan(s * Pi / 128.0) * 281474976710656.0;
         tab[s] = TanFrac'(longint'(t));
      end
      return tab;
   endfunction

   localparam tan_arr_type TanTab = build_tan();

   typedef struct packed {
      logic                  valid;
      logic [7:0]            frame;
      logic                  zero;
      logic [1:0]            quad;
      logic                  eq;
      logic                  sw;
      logic [MagBits-1:0]    hi;
      logic [MagBits-1:0]    lo;
      logic [R2Bits-1:0]     r2;
      logic [SectorBits-1:0] sec;
      logic [RootBits-1:0]   root;
      logic [SqBits-1:0]     sq;
   } pipe_type;

endpackage

FILE: design/tunnel_pixel_generator_unit.sv
// Throughput: one transaction per cycle; busy is never raised.
// The depth is set by the twelve-step root search, one stage per result bit.
// The receiver cannot stall, so results leave on a fixed schedule.
// Synchronous reset clears every valid bit; pixels in flight are dropped.
module tunnel_pixel_generator_unit import tpg_pkg::*; #(
   parameter int SCREEN_WIDTH  = DefScreenWidth,
   parameter int SCREEN_HEIGHT = DefScreenHeight
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [8:0] req_pixel_x,
   input  logic [7:0] req_pixel_y,
   input  logic [7:0] req_frame_count,
   output logic       rsp_valid,
   output logic [7:0] rsp_texel_color
);

   pipe_type stage [DepthSteps+1];

   assign busy = 1'b0;

   tpg_front #(
      .SCREEN_WIDTH (SCREEN_WIDTH),
      .SCREEN_HEIGHT(SCREEN_HEIGHT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (start && !busy),
      .pixel_x    (req_pixel_x),
      .pixel_y    (req_pixel_y),
      .frame_count(req_frame_count),
      .out        (stage[0])
   );

   for (genvar i = 0; i < DepthSteps; i++) begin : g_search
      tpg_search_stage #(.STEP(i)) u_stage (
         .clock(clock),
         .reset(reset),
         .in   (stage[i]),
         .out  (stage[i+1])
      );
   end

   tpg_texel u_texel (
      .clock    (clock),
      .reset    (reset),
      .in       (stage[DepthSteps]),
      .out_valid(rsp_valid),
      .texel    (rsp_texel_color)
   );

`ifndef SYNTHESIS
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##16 rsp_valid)
      else $error("accepted transaction produced no result");
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |-> ##16 !rsp_valid)
      else $error("result without an accepted transaction");
   a_mid_valid: assert property (@(posedge clock) disable iff (reset)
      stage[DepthSteps].valid |-> ##2 rsp_valid)
      else $error("back end lost a transaction");
`endif

endmodule

FILE: design/tpg_front.sv
// Front end: centre offsets, octant reduction and squared radius.
module tpg_front import tpg_pkg::*; #(
   parameter int SCREEN_WIDTH  = DefScreenWidth,
   parameter int SCREEN_HEIGHT = DefScreenHeight
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  logic [8:0] pixel_x,
   input  logic [7:0] pixel_y,
   input  logic [7:0] frame_count,
   output pipe_type   out
);

   localparam int HalfW = SCREEN_WIDTH / 2;
   localparam int HalfH = SCREEN_HEIGHT / 2;

   logic                        v1_ff;
   logic [7:0]                  fr1_ff;
   logic signed [CoordBits-1:0] dx_ff, dy_ff;
   logic signed [CoordBits-1:0] dx_in, dy_in;
   logic signed [CoordBits-1:0] a_s, b_s;
   logic [MagBits-1:0]          a_m, b_m;
   logic [1:0]                  quad;
   logic [2*CoordBits-1:0]      r2_full;
   pipe_type                    out_ff, out_in;

   assign dx_in = $signed({3'b000, pixel_x}) - CoordBits'(HalfW);
   assign dy_in = $signed({4'b0000, pixel_y}) - CoordBits'(HalfH);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
      end
      dx_ff  <= dx_in;
      dy_ff  <= dy_in;
      fr1_ff <= frame_count;
   end

   always_comb begin
      if (dy_ff >= 0 && dx_ff > 0) begin
         quad = 2'd0; a_s = dx_ff;  b_s = dy_ff;
      end else if (dx_ff <= 0 && dy_ff > 0) begin
         quad = 2'd1; a_s = dy_ff;  b_s = -dx_ff;
      end else if (dy_ff <= 0 && dx_ff < 0) begin
         quad = 2'd2; a_s = -dx_ff; b_s = -dy_ff;
      end else begin
         quad = 2'd3; a_s = -dy_ff; b_s = dx_ff;
      end
      a_m = a_s[MagBits-1:0];
      b_m = b_s[MagBits-1:0];
      r2_full = (2*CoordBits)'(dx_ff * dx_ff) + (2*CoordBits)'(dy_ff * dy_ff);

      out_in       = '0;
      out_in.valid = v1_ff;
      out_in.frame = fr1_ff;
      out_in.zero  = (dx_ff == 0) && (dy_ff == 0);
      out_in.quad  = quad;
      out_in.eq    = (a_m == b_m);
      out_in.sw    = (b_m > a_m);
      out_in.hi    = (b_m > a_m) ? b_m : a_m;
      out_in.lo    = (b_m > a_m) ? a_m : b_m;
      out_in.r2    = (r2_full == '0) ? R2Bits'(1) : r2_full[R2Bits-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else begin
         out_ff.valid <= out_in.valid;
      end
      out_ff.frame <= out_in.frame;
      out_ff.zero  <= out_in.zero;
      out_ff.quad  <= out_in.quad;
      out_ff.eq    <= out_in.eq;
      out_ff.sw    <= out_in.sw;
      out_ff.hi    <= out_in.hi;
      out_ff.lo    <= out_in.lo;
      out_ff.r2    <= out_in.r2;
      out_ff.sec   <= out_in.sec;
      out_ff.root  <= out_in.root;
      out_ff.sq    <= out_in.sq;
   end

   assign out = out_ff;

endmodule

FILE: design/tpg_search_stage.sv
// One stage of the sector search and of the bit-by-bit depth root search.
module tpg_search_stage import tpg_pkg::*; #(
   parameter int STEP = 0
) (
   input  logic     clock,
   input  logic     reset,
   input  pipe_type in,
   output pipe_type out
);

   localparam int DepthBit = RootBits - 1 - STEP;

   logic [SectorBits-1:0]        cand;
   logic [MagBits+TanFrac-1:0]   lhs, rhs;
   logic [RootBits-1:0]          t_root;
   logic [SqBits+1:0]            t_sq;
   logic [SqBits+R2Bits-1:0]     prod;
   logic                         fits;
   pipe_type                     out_ff, out_in;

   always_comb begin
      out_in = in;
      // Sector bits are settled over the first stages; later ones pass them on.
      cand = in.sec;
      lhs  = '0;
      rhs  = '0;
      if (STEP < SectorBits) begin
         cand = in.sec | SectorBits'(1 << (SectorBits - 1 - STEP));
         lhs  = {in.lo, TanFrac'(0)};
         rhs  = (MagBits+TanFrac)'(in.hi) * (MagBits+TanFrac)'(TanTab[cand]);
         if (lhs >= rhs) begin
            out_in.sec = cand;
         end
      end
      // (root + bit)^2 = root^2 + 2*root*bit + bit^2.
      t_root = in.root | RootBits'(1 << DepthBit);
      t_sq   = (SqBits+2)'(in.sq) + ((SqBits+2)'(in.root) << (DepthBit + 1))
               + ((SqBits+2)'(1) << (2 * DepthBit));
      prod   = (SqBits+R2Bits)'(t_sq[SqBits-1:0]) * (SqBits+R2Bits)'(in.r2);
      fits   = (t_sq <= (SqBits+2)'(DepthScale)) && (prod <= (SqBits+R2Bits)'(DepthScale));
      if (fits) begin
         out_in.root = t_root;
         out_in.sq   = t_sq[SqBits-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else begin
         out_ff.valid <= out_in.valid;
      end
      out_ff.frame <= out_in.frame;
      out_ff.zero  <= out_in.zero;
      out_ff.quad  <= out_in.quad;
      out_ff.eq    <= out_in.eq;
      out_ff.sw    <= out_in.sw;
      out_ff.hi    <= out_in.hi;
      out_ff.lo    <= out_in.lo;
      out_ff.r2    <= out_in.r2;
      out_ff.sec   <= out_in.sec;
      out_ff.root  <= out_in.root;
      out_ff.sq    <= out_in.sq;
   end

   assign out = out_ff;

`ifndef SYNTHESIS
   a_sq_bound: assert property (@(posedge clock) disable iff (reset)
      out_ff.valid |-> out_ff.sq <= DepthScale)
      else $error("depth square exceeds scale");
   a_sq_match: assert property (@(posedge clock) disable iff (reset)
      out_ff.valid |-> (2*RootBits)'(out_ff.root) * (2*RootBits)'(out_ff.root)
                       == (2*RootBits)'(out_ff.sq))
      else $error("depth square out of step with root");
`endif

endmodule

FILE: design/tpg_texel.sv
// Back end: angle byte, texture coordinates and the procedural texel.
module tpg_texel import tpg_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  pipe_type   in,
   output logic       out_valid,
   output logic [7:0] texel
);

   logic        v1_ff, v2_ff;
   logic [7:0]  u_ff, v_ff;
   logic [15:0] prod_ff;
   logic [7:0]  sec8, ang, u_in, v_in;
   logic [7:0]  texel_ff;

   always_comb begin
      if (in.eq) begin
         sec8 = 8'd32;
      end else if (in.sw) begin
         sec8 = 8'd63 - {3'b000, in.sec};
      end else begin
         sec8 = {3'b000, in.sec};
      end
      ang  = in.zero ? 8'd128 : ({in.quad, 6'b000000} + sec8 + 8'd128);
      u_in = ang + {in.frame[6:0], 1'b0};
      v_in = in.root[7:0] + in.frame;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in.valid;
         v2_ff <= v1_ff;
      end
      u_ff     <= u_in;
      v_ff     <= v_in;
      prod_ff  <= 16'(u_in) * 16'(v_in);
      texel_ff <= (u_ff ^ v_ff) + prod_ff[13:6];
   end

   assign out_valid = v2_ff;
   assign texel     = texel_ff;

endmodule
